// ----- design/rlsp_pkg.sv -----
// Shared types and constants of the rate-limited stream packetizer.
package rlsp_pkg;

  localparam int PacketBytesDef = 150;
  localparam int BufferBytesDef = 16384;
  localparam int WindowSlotsDef = 128;

  localparam logic [1:0] KIND_APPEND   = 2'd0;
  localparam logic [1:0] KIND_SEND     = 2'd1;
  localparam logic [1:0] KIND_TRIM     = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic [1:0] CFG_WINDOW  = 2'd0;
  localparam logic [1:0] CFG_BUDGET  = 2'd1;
  localparam logic [1:0] CFG_BACKLOG = 2'd2;

  localparam logic [2:0] STATUS_STORED = 3'd0;
  localparam logic [2:0] STATUS_LOST   = 3'd1;
  localparam logic [2:0] STATUS_WORD   = 3'd2;
  localparam logic [2:0] STATUS_NONE   = 3'd3;
  localparam logic [2:0] STATUS_TRIM   = 3'd4;

  localparam logic [39:0] WINDOW_RST  = 40'd2000000000;
  localparam logic [14:0] BUDGET_RST  = 15'd14000;
  localparam logic [14:0] BACKLOG_RST = 15'd7000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [62:0] now;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] payload;
    logic [4:0]  word_number;
    logic        last_word;
    logic [31:0] sequence_num;
    logic [62:0] time_ns;
    logic [14:0] dropped;
    logic [14:0] backlog;
  } result_t;

endpackage

// ----- design/rlsp_front.sv -----
// Front end: accepts items, discards unknown kinds, queues the rest.
module rlsp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  logic [7:0]           stream_byte_i,
  input  logic [62:0]          now_time_ns_i,
  output logic                 item_valid_o,
  output rlsp_pkg::item_t      item_o,
  input  logic                 item_pop_i
);
  import rlsp_pkg::*;

  item_t       fifo_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  fill_q;
  logic        known;
  logic        push;

  assign known        = (kind_i == KIND_APPEND) || (kind_i == KIND_SEND) ||
                        (kind_i == KIND_TRIM);
  assign in_ready_o   = (fill_q != 2'd2);
  assign push         = in_valid_i && in_ready_o && known;
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o       = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= '{kind: kind_i, data: stream_byte_i, now: now_time_ns_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (item_pop_i) rptr_q <= ~rptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, item_pop_i};
    end
  end

endmodule

// ----- design/rlsp_back.sv -----
// Back end: byte store, stamp window, packet and trim sequencing, result register.
module rlsp_back #(
  parameter int PKT_SIZE     = rlsp_pkg::PacketBytesDef,
  parameter int BUFFER_BYTES = rlsp_pkg::BufferBytesDef,
  parameter int WINDOW_SLOTS = rlsp_pkg::WindowSlotsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [39:0]          cfg_wdata_i,
  input  logic                 item_valid_i,
  input  rlsp_pkg::item_t      item_i,
  output logic                 item_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rlsp_pkg::result_t    out_o
);
  import rlsp_pkg::*;

  localparam int AW  = $clog2(BUFFER_BYTES);
  localparam int CW  = $clog2(BUFFER_BYTES + 1);
  localparam int SW  = $clog2(WINDOW_SLOTS);
  localparam int SCW = $clog2(WINDOW_SLOTS + 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EXP_RD  = 9'b000000010,
    S_EXP_CHK = 9'b000000100,
    S_DECIDE  = 9'b000001000,
    S_RD      = 9'b000010000,
    S_ACC     = 9'b000100000,
    S_TRD     = 9'b001000000,
    S_TACC    = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_e;

  function automatic logic [AW-1:0] badd(logic [AW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(BUFFER_BYTES)) s = s - (CW+1)'(BUFFER_BYTES);
    return s[AW-1:0];
  endfunction

  function automatic logic [SW-1:0] sadd(logic [SW-1:0] a, logic [SCW-1:0] b);
    logic [SCW:0] s;
    s = (SCW+1)'(a) + (SCW+1)'(b);
    if (s >= (SCW+1)'(WINDOW_SLOTS)) s = s - (SCW+1)'(WINDOW_SLOTS);
    return s[SW-1:0];
  endfunction

  logic [7:0]  byte_mem [BUFFER_BYTES];
  logic [62:0] stamp_mem [WINDOW_SLOTS];
  logic [7:0]  byte_rd_q;
  logic [62:0] stamp_rd_q;

  state_e          state_q, state_d;
  logic [AW-1:0]   head_q, head_d, rd_addr_q, rd_addr_d;
  logic [CW-1:0]   count_q, count_d, idx_q, idx_d, tgt_q, tgt_d;
  logic [SW-1:0]   sthead_q, sthead_d;
  logic [SCW-1:0]  stcount_q, stcount_d;
  logic [31:0]     seq_q, seq_d;
  logic [39:0]     win_q, win_d;
  logic [14:0]     budget_q, budget_d, limit_q, limit_d;
  item_t           item_q, item_d;
  logic [63:0]     word_q, word_d;
  logic [2:0]      lane_q, lane_d;
  logic [4:0]      wnum_q, wnum_d;
  logic [31:0]     win4_q, win4_d;
  logic [1:0]      nfill_q, nfill_d;
  logic            more_q, more_d;
  logic            valid_q, valid_d;
  result_t         res_q, res_d;

  logic            byte_we, st_we;
  logic [AW-1:0]   byte_waddr;
  logic [CW-1:0]   dropped;
  logic [CW-1:0]   pkt_len;

  assign pkt_len     = CW'(PKT_SIZE);
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (byte_we) byte_mem[byte_waddr] <= item_i.data;
    byte_rd_q <= byte_mem[rd_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) stamp_mem[sadd(sthead_q, stcount_q)] <= item_q.now;
    stamp_rd_q <= stamp_mem[sthead_q];
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    rd_addr_d = rd_addr_q;
    idx_d     = idx_q;
    tgt_d     = tgt_q;
    sthead_d  = sthead_q;
    stcount_d = stcount_q;
    seq_d     = seq_q;
    win_d     = win_q;
    budget_d  = budget_q;
    limit_d   = limit_q;
    item_d    = item_q;
    word_d    = word_q;
    lane_d    = lane_q;
    wnum_d    = wnum_q;
    win4_d    = win4_q;
    nfill_d   = nfill_q;
    more_d    = more_q;
    valid_d   = valid_q;
    res_d     = res_q;
    byte_we   = 1'b0;
    byte_waddr = badd(head_q, count_q);
    st_we     = 1'b0;
    item_pop_o = 1'b0;
    dropped   = tgt_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW:  win_d    = cfg_wdata_i;
        CFG_BUDGET:  budget_d = cfg_wdata_i[14:0];
        CFG_BACKLOG: limit_d  = cfg_wdata_i[14:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          case (item_i.kind)
            KIND_APPEND: begin
              if (count_q >= CW'(BUFFER_BYTES)) begin
                res_d = '{STATUS_LOST, 64'd0, 5'd0, 1'b1, 32'd0, 63'd0, 15'd0,
                          15'(count_q)};
              end else begin
                byte_we = 1'b1;
                count_d = count_q + CW'(1);
                res_d = '{STATUS_STORED, 64'd0, 5'd0, 1'b1, 32'd0, 63'd0, 15'd0,
                          15'(count_d)};
              end
              valid_d = 1'b1;
              more_d  = 1'b0;
              state_d = S_OUT;
            end
            KIND_SEND: begin
              state_d = (stcount_q != '0) ? S_EXP_RD : S_DECIDE;
            end
            KIND_TRIM: begin
              if (32'(count_q) > 32'(limit_q)) begin
                tgt_d = CW'(32'(count_q) - 32'(limit_q));
                if (32'(tgt_d) + 32'd4 < 32'(count_q)) begin
                  rd_addr_d = badd(head_q, tgt_d);
                  idx_d     = tgt_d;
                  nfill_d   = 2'd0;
                  state_d   = S_TRD;
                end else begin
                  head_d  = badd(head_q, tgt_d);
                  count_d = count_q - tgt_d;
                  res_d = '{STATUS_TRIM, 64'd0, 5'd0, 1'b1, 32'd0, 63'd0, 15'(tgt_d),
                            15'(count_d)};
                  valid_d = 1'b1;
                  more_d  = 1'b0;
                  state_d = S_OUT;
                end
              end else begin
                res_d = '{STATUS_TRIM, 64'd0, 5'd0, 1'b1, 32'd0, 63'd0, 15'd0,
                          15'(count_q)};
                valid_d = 1'b1;
                more_d  = 1'b0;
                state_d = S_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      S_EXP_RD: state_d = S_EXP_CHK;
      S_EXP_CHK: begin
        if ((item_q.now > stamp_rd_q) &&
            ((item_q.now - stamp_rd_q) > 63'(win_q))) begin
          sthead_d  = sadd(sthead_q, SCW'(1));
          stcount_d = stcount_q - SCW'(1);
          state_d   = (stcount_q == SCW'(1)) ? S_DECIDE : S_EXP_RD;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if ((count_q < pkt_len) || (32'(stcount_q) >= 32'(WINDOW_SLOTS)) ||
            ((32'(stcount_q) + 32'd1) * 32'(PKT_SIZE) > 32'(budget_q))) begin
          res_d = '{STATUS_NONE, 64'd0, 5'd0, 1'b1, 32'd0, 63'd0, 15'd0,
                    15'(count_q)};
          valid_d = 1'b1;
          more_d  = 1'b0;
          state_d = S_OUT;
        end else begin
          st_we     = 1'b1;
          stcount_d = stcount_q + SCW'(1);
          seq_d     = seq_q + 32'd1;
          rd_addr_d = head_q;
          head_d    = badd(head_q, pkt_len);
          count_d   = count_q - pkt_len;
          res_d = '{STATUS_WORD, 64'd0, 5'd0, 1'b0, seq_q, item_q.now, 15'd0,
                    15'(count_d)};
          idx_d   = '0;
          lane_d  = 3'd0;
          word_d  = 64'd0;
          wnum_d  = 5'd0;
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_ACC;
      S_ACC: begin
        word_d[lane_q*8 +: 8] = byte_rd_q;
        idx_d     = idx_q + CW'(1);
        rd_addr_d = badd(rd_addr_q, CW'(1));
        lane_d    = lane_q + 3'd1;
        if ((lane_q == 3'd7) || (idx_q == pkt_len - CW'(1))) begin
          res_d.payload     = word_d;
          res_d.word_number = wnum_q;
          res_d.last_word   = (idx_q == pkt_len - CW'(1));
          more_d  = (idx_q != pkt_len - CW'(1));
          valid_d = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_RD;
        end
      end
      S_TRD: state_d = S_TACC;
      S_TACC: begin
        win4_d  = {byte_rd_q, win4_q[31:8]};
        nfill_d = (nfill_q == 2'd3) ? 2'd3 : nfill_q + 2'd1;
        if ((nfill_q == 2'd3) && (win4_d[7:0] == 8'd0) && (win4_d[15:8] == 8'd0) &&
            ((win4_d[23:16] == 8'd1) ||
             ((win4_d[23:16] == 8'd0) && (win4_d[31:24] == 8'd1)))) begin
          dropped = idx_q - CW'(3);
          head_d  = badd(head_q, dropped);
          count_d = count_q - dropped;
          res_d = '{STATUS_TRIM, 64'd0, 5'd0, 1'b1, 32'd0, 63'd0, 15'(dropped),
                    15'(count_d)};
          valid_d = 1'b1;
          more_d  = 1'b0;
          state_d = S_OUT;
        end else if (32'(idx_q) + 32'd2 < 32'(count_q)) begin
          idx_d     = idx_q + CW'(1);
          rd_addr_d = badd(rd_addr_q, CW'(1));
          state_d   = S_TRD;
        end else begin
          head_d  = badd(head_q, tgt_q);
          count_d = count_q - tgt_q;
          res_d = '{STATUS_TRIM, 64'd0, 5'd0, 1'b1, 32'd0, 63'd0, 15'(tgt_q),
                    15'(count_d)};
          valid_d = 1'b1;
          more_d  = 1'b0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          valid_d = 1'b0;
          if (more_q) begin
            word_d  = 64'd0;
            lane_d  = 3'd0;
            wnum_d  = wnum_q + 5'd1;
            state_d = S_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    idx_q     <= idx_d;
    tgt_q     <= tgt_d;
    item_q    <= item_d;
    word_q    <= word_d;
    lane_q    <= lane_d;
    wnum_q    <= wnum_d;
    win4_q    <= win4_d;
    nfill_q   <= nfill_d;
    more_q    <= more_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      sthead_q  <= '0;
      stcount_q <= '0;
      seq_q     <= 32'd0;
      win_q     <= WINDOW_RST;
      budget_q  <= BUDGET_RST;
      limit_q   <= BACKLOG_RST;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      sthead_q  <= sthead_d;
      stcount_q <= stcount_d;
      seq_q     <= seq_d;
      win_q     <= win_d;
      budget_q  <= budget_d;
      limit_q   <= limit_d;
      valid_q   <= valid_d;
    end
  end

endmodule

// ----- design/rate_limited_stream_packetizer.sv -----
// Top level of the rate-limited stream packetizer.
// Bytes are appended one per item into a circular store of BUFFER_BYTES
// entries; a send item expires window stamps (each read, then checked),
// then either answers "no packet" or streams one PKT_SIZE-byte packet as
// ceil(PKT_SIZE/8) 64-bit words, each with sequence number and send time.
// A trim item cuts the backlog down to backlog_limit_bytes, moving the cut to
// the first start code at or after it, if one is found. Items are queued
// two deep at the input, so the source can push while a result waits on the
// output. The back end handles one item at a time: a send reads each stamp,
// then each packet byte, handing off each word as it fills; a trim scans the
// store byte by byte. Bytes come through the registered read of the byte
// store. Configuration writes take effect at once and belong to idle periods.
// Kind 3 items are accepted and dropped.
module rate_limited_stream_packetizer #(
  parameter int PKT_SIZE     = rlsp_pkg::PacketBytesDef,
  parameter int BUFFER_BYTES = rlsp_pkg::BufferBytesDef,
  parameter int WINDOW_SLOTS = rlsp_pkg::WindowSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [39:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  stream_byte_i,
  input  logic [62:0] now_time_ns_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] payload_word_o,
  output logic [4:0]  word_number_o,
  output logic        last_word_o,
  output logic [31:0] packet_sequence_o,
  output logic [62:0] packet_time_ns_o,
  output logic [14:0] bytes_dropped_o,
  output logic [14:0] backlog_bytes_o
);
  import rlsp_pkg::*;

  item_t   item;
  logic    item_valid, item_pop;
  result_t res;

  // front: accept and queue items
  rlsp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .stream_byte_i (stream_byte_i),
    .now_time_ns_i (now_time_ns_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  // back: execute items against the byte store and stamp window
  rlsp_back #(
    .PKT_SIZE     (PKT_SIZE),
    .BUFFER_BYTES (BUFFER_BYTES),
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (res)
  );

  assign status_o          = res.status;
  assign payload_word_o    = res.payload;
  assign word_number_o     = res.word_number;
  assign last_word_o       = res.last_word;
  assign packet_sequence_o = res.sequence_num;
  assign packet_time_ns_o  = res.time_ns;
  assign bytes_dropped_o   = res.dropped;
  assign backlog_bytes_o   = res.backlog;

endmodule
